FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/dre_pkg.sv
// ---------------------------------------------------------------------------
// dre_pkg
// Types and constants of the DNS response A-record extractor.
// ---------------------------------------------------------------------------
package dre_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int MIN_HEADER_BYTES = 12;
    localparam int AHDR_BYTES       = 10;
    localparam int QFIXED_BYTES     = 4;
    localparam int ADDR_BYTES       = 4;

    typedef enum logic [2:0] {
        ST_FOUND        = 3'd0,
        ST_SHORT        = 3'd1,
        ST_NOT_RESPONSE = 3'd2,
        ST_NO_ANSWERS   = 3'd3,
        ST_MALFORMED    = 3'd4,
        ST_NO_A         = 3'd5,
        ST_UNDECIDED    = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_NAME    = 4'd1,
        PH_LABEL   = 4'd2,
        PH_POINTER = 4'd3,
        PH_QFIXED  = 4'd4,
        PH_AHEADER = 4'd5,
        PH_AADDR   = 4'd6,
        PH_RDATA   = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
    } t_result;

endpackage

FILE: src/dre_if.sv
// ---------------------------------------------------------------------------
// dre_byte_if / dre_result_if
// Valid/ready channels for packet bytes and for results.
// ---------------------------------------------------------------------------
interface dre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dre_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

FILE: src/dns_response_a_record_extractor.sv
// DNS response A-record extractor: takes one packet byte per cycle with no
// gaps of its own, one byte per transfer; the parse state advances in the
// same cycle the byte is taken and is cleared on the byte marked last. The
// status and address of that byte are written to a two-entry result queue
// and are offered on the result channel behind any older result. The byte
// channel stalls only while both queue entries are held by results not taken.
// ---------------------------------------------------------------------------
// dns_response_a_record_extractor
// Top level: byte parser and result queue.
// ---------------------------------------------------------------------------
module dns_response_a_record_extractor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dre_byte_if.sink     i_byte,
    dre_result_if.source o_result
);
    import dre_pkg::*;

    logic    push;
    logic    space;
    t_result res;

    dre_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_space (space),
        .o_push  (push),
        .o_res   (res)
    );

    dre_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res    (res),
        .o_space  (space),
        .o_result (o_result)
    );

endmodule

FILE: src/dre_parser.sv
// ---------------------------------------------------------------------------
// dre_parser
// Byte-wise DNS parse state; produces one result on the last byte.
// ---------------------------------------------------------------------------
module dre_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dre_byte_if.sink         i_byte,
    input  logic             i_space,
    output logic             o_push,
    output dre_pkg::t_result o_res
);
    import dre_pkg::*;

    logic [POS_W-1:0] r_pos,     n_pos;
    t_phase           r_phase,   n_phase;
    logic [15:0]      r_qleft,   n_qleft;
    logic [15:0]      r_aleft,   n_aleft;
    logic [15:0]      r_skip,    n_skip;
    logic [15:0]      r_fshift,  n_fshift;
    logic [15:0]      r_rtype,   n_rtype;
    logic [31:0]      r_addr,    n_addr;
    t_status          r_verdict, n_verdict;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] dec;
    logic [3:0]  idx;
    t_status     status;

    assign i_byte.ready = i_space;
    assign accept       = i_byte.valid && i_space;
    assign b            = i_byte.data_byte;
    assign dec          = r_skip - 16'd1;
    assign idx          = 4'(AHDR_BYTES) - r_skip[3:0];

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_qleft   = r_qleft;
        n_aleft   = r_aleft;
        n_skip    = r_skip;
        n_fshift  = r_fshift;
        n_rtype   = r_rtype;
        n_addr    = r_addr;
        n_verdict = r_verdict;
        if (r_pos < POS_W'(MAX_PACKET_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(2) && !b[7]) n_verdict = ST_NOT_RESPONSE;
                    if (r_pos == POS_W'(4)) n_qleft = {b, 8'h00};
                    if (r_pos == POS_W'(5)) n_qleft = {r_qleft[15:8], b};
                    if (r_pos == POS_W'(6)) n_aleft = {b, 8'h00};
                    if (r_pos == POS_W'(7)) begin
                        n_aleft = {r_aleft[15:8], b};
                        if (r_verdict == ST_UNDECIDED && {r_aleft[15:8], b} == 16'd0)
                            n_verdict = ST_NO_ANSWERS;
                    end
                    if (r_pos == POS_W'(11))
                        n_phase = (r_verdict == ST_UNDECIDED) ? PH_NAME : PH_DONE;
                end
                PH_NAME: begin
                    if (b[7:6] == 2'b11) begin
                        n_phase = PH_POINTER;
                    end else if (b == 8'd0) begin
                        if (r_qleft != 16'd0) begin
                            n_phase = PH_QFIXED;
                            n_skip  = 16'(QFIXED_BYTES);
                        end else begin
                            n_phase  = PH_AHEADER;
                            n_skip   = 16'(AHDR_BYTES);
                            n_fshift = 16'd0;
                            n_rtype  = 16'd0;
                        end
                    end else begin
                        n_skip  = {8'h00, b};
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_skip = dec;
                    if (dec == 16'd0) n_phase = PH_NAME;
                end
                PH_POINTER: begin
                    if (r_qleft != 16'd0) begin
                        n_phase = PH_QFIXED;
                        n_skip  = 16'(QFIXED_BYTES);
                    end else begin
                        n_phase  = PH_AHEADER;
                        n_skip   = 16'(AHDR_BYTES);
                        n_fshift = 16'd0;
                        n_rtype  = 16'd0;
                    end
                end
                PH_QFIXED: begin
                    n_skip = dec;
                    if (dec == 16'd0) begin
                        n_qleft = r_qleft - 16'd1;
                        n_phase = PH_NAME;
                    end
                end
                PH_AHEADER: begin
                    if (idx == 4'd0) n_rtype  = {b, 8'h00};
                    if (idx == 4'd1) n_rtype  = {r_rtype[15:8], b};
                    if (idx == 4'd8) n_fshift = {b, 8'h00};
                    if (idx == 4'd9) n_fshift = {r_fshift[15:8], b};
                    n_skip = dec;
                    if (dec == 16'd0) begin
                        if (n_rtype == 16'd1 && n_fshift == 16'(ADDR_BYTES)) begin
                            n_phase = PH_AADDR;
                            n_skip  = 16'(ADDR_BYTES);
                            n_addr  = 32'd0;
                        end else if (n_fshift == 16'd0) begin
                            n_aleft = r_aleft - 16'd1;
                            if (r_aleft == 16'd1) begin
                                n_verdict = ST_NO_A;
                                n_phase   = PH_DONE;
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end else begin
                            n_phase = PH_RDATA;
                            n_skip  = n_fshift;
                        end
                    end
                end
                PH_AADDR: begin
                    n_addr = {r_addr[23:0], b};
                    n_skip = dec;
                    if (dec == 16'd0) begin
                        n_verdict = ST_FOUND;
                        n_phase   = PH_DONE;
                    end
                end
                PH_RDATA: begin
                    n_skip = dec;
                    if (dec == 16'd0) begin
                        n_aleft = r_aleft - 16'd1;
                        if (r_aleft == 16'd1) begin
                            n_verdict = ST_NO_A;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_NAME;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (n_pos < POS_W'(MIN_HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (n_phase == PH_DONE) begin
            status = (n_verdict == ST_UNDECIDED) ? ST_MALFORMED : n_verdict;
        end else if (n_phase == PH_AADDR || n_phase == PH_RDATA) begin
            status = (n_aleft == 16'd1) ? ST_NO_A : ST_MALFORMED;
        end else begin
            status = ST_MALFORMED;
        end
    end

    assign o_push        = accept && i_byte.last;
    assign o_res.status  = status;
    assign o_res.address = (status == ST_FOUND) ? n_addr : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_byte.last)) begin
            r_pos     <= '0;
            r_phase   <= PH_HEADER;
            r_qleft   <= '0;
            r_aleft   <= '0;
            r_skip    <= '0;
            r_fshift  <= '0;
            r_rtype   <= '0;
            r_addr    <= '0;
            r_verdict <= ST_UNDECIDED;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_qleft   <= n_qleft;
            r_aleft   <= n_aleft;
            r_skip    <= n_skip;
            r_fshift  <= n_fshift;
            r_rtype   <= n_rtype;
            r_addr    <= n_addr;
            r_verdict <= n_verdict;
        end
    end

endmodule

FILE: src/dre_outq.sv
// ---------------------------------------------------------------------------
// dre_outq
// Two-entry result queue in front of the result channel.
// ---------------------------------------------------------------------------
module dre_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dre_pkg::t_result i_res,
    output logic             o_space,
    dre_result_if.source     o_result
);
    import dre_pkg::*;

    t_result    r_ent0, r_ent1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop              = (r_cnt != 2'd0) && o_result.ready;
    assign o_space          = (r_cnt != 2'd2);
    assign o_result.valid   = (r_cnt != 2'd0);
    assign o_result.status  = r_ent0.status;
    assign o_result.address = r_ent0.address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ent0 <= (i_push && r_cnt == 2'd1) ? i_res : r_ent1;
            if (i_push && r_cnt == 2'd2) r_ent1 <= i_res;
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_ent0 <= i_res;
            end else begin
                r_ent1 <= i_res;
            end
        end
    end

endmodule

FILE: src/dre_checker.sv
// ---------------------------------------------------------------------------
// dre_checker
// Port-level checks of the A-record extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_address
);
    import dre_pkg::*;

    `DRE_ASSERT_IMP(a_status_range, i_clk, i_rst_n, i_out_valid, i_status <= ST_NO_A)
    `DRE_ASSERT_IMP(a_addr_zero, i_clk, i_rst_n, i_out_valid && i_status != ST_FOUND, i_address == 32'd0)
    `DRE_ASSERT_IMP(a_result_after_last, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last))
    `DRE_ASSERT_NXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_address))

endmodule

bind dns_response_a_record_extractor dre_checker u_dre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_last   (i_byte.last),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status),
    .i_address   (o_result.address)
);

FILE: sim/dns_response_a_record_extractor_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dns_response_a_record_extractor_test
// Feeds DNS response packets one byte per transfer (directed packets for each
// verdict, truncations and the byte limit, then mostly well-formed random
// traffic with noise), predicts the status and address of every packet and
// compares each result transfer against the oldest prediction. Both channel
// sides idle at random; the result side is held off once to fill the block.
// ---------------------------------------------------------------------------
module dns_response_a_record_extractor_test;
    import dre_pkg::*;

    logic i_clk;
    logic i_rst_n;

    dre_byte_if   bytes_ch ();
    dre_result_if verdict_ch ();

    dns_response_a_record_extractor u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (bytes_ch),
        .o_result (verdict_ch)
    );

    // parser state of the prediction
    logic [POS_W-1:0] pr_pos;
    t_phase           pr_phase;
    logic [15:0]      pr_qleft;
    logic [15:0]      pr_aleft;
    logic [15:0]      pr_skip;
    logic [15:0]      pr_rdlen;
    logic [15:0]      pr_rtype;
    logic [31:0]      pr_addr;
    t_status          pr_verdict;

    t_result    owed_verdicts[$];
    logic [7:0] frame[$];

    int  fail_count    = 0;
    int  bytes_sent    = 0;
    int  rx_hold_cycles = 0;
    bit  tx_eager      = 1'b0;
    bit  rx_eager      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------ prediction
    function automatic void clear_parse();
        pr_pos     = '0;
        pr_phase   = PH_HEADER;
        pr_qleft   = '0;
        pr_aleft   = '0;
        pr_skip    = '0;
        pr_rdlen   = '0;
        pr_rtype   = '0;
        pr_addr    = '0;
        pr_verdict = ST_UNDECIDED;
    endfunction

    function automatic void finish_name();
        if (pr_qleft != 0) begin
            pr_phase = PH_QFIXED;
            pr_skip  = 16'(QFIXED_BYTES);
        end else begin
            pr_phase = PH_AHEADER;
            pr_skip  = 16'(AHDR_BYTES);
            pr_rdlen = '0;
            pr_rtype = '0;
        end
    endfunction

    function automatic void finish_record();
        pr_aleft = pr_aleft - 16'd1;
        if (pr_aleft == 0) begin
            pr_verdict = ST_NO_A;
            pr_phase   = PH_DONE;
        end else begin
            pr_phase = PH_NAME;
        end
    endfunction

    function automatic void dns_parse_byte(logic [7:0] b, logic is_last);
        int      idx;
        t_status st;
        t_result r;
        if (pr_pos < MAX_PACKET_BYTES) begin
            case (pr_phase)
                PH_HEADER: begin
                    case (pr_pos)
                        2: if (!b[7]) pr_verdict = ST_NOT_RESPONSE;
                        4: pr_qleft = {b, 8'h00};
                        5: pr_qleft[7:0] = b;
                        6: pr_aleft = {b, 8'h00};
                        7: begin
                            pr_aleft[7:0] = b;
                            if (pr_verdict == ST_UNDECIDED && pr_aleft == 0)
                                pr_verdict = ST_NO_ANSWERS;
                        end
                        11: begin
                            if (pr_verdict == ST_UNDECIDED) pr_phase = PH_NAME;
                            else pr_phase = PH_DONE;
                        end
                        default: ;
                    endcase
                end
                PH_NAME: begin
                    if (b[7:6] == 2'b11) begin
                        pr_phase = PH_POINTER;
                    end else if (b == 8'h00) begin
                        finish_name();
                    end else begin
                        pr_skip  = {8'h00, b};
                        pr_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 0) pr_phase = PH_NAME;
                end
                PH_POINTER: finish_name();
                PH_QFIXED: begin
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 0) begin
                        pr_qleft = pr_qleft - 16'd1;
                        pr_phase = PH_NAME;
                    end
                end
                PH_AHEADER: begin
                    idx = AHDR_BYTES - int'(pr_skip);
                    case (idx)
                        0: pr_rtype = {b, 8'h00};
                        1: pr_rtype[7:0] = b;
                        8: pr_rdlen = {b, 8'h00};
                        9: pr_rdlen[7:0] = b;
                        default: ;
                    endcase
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 0) begin
                        if (pr_rtype == 16'd1 && pr_rdlen == ADDR_BYTES) begin
                            pr_phase = PH_AADDR;
                            pr_skip  = 16'(ADDR_BYTES);
                            pr_addr  = '0;
                        end else if (pr_rdlen == 0) begin
                            finish_record();
                        end else begin
                            pr_phase = PH_RDATA;
                            pr_skip  = pr_rdlen;
                        end
                    end
                end
                PH_AADDR: begin
                    pr_addr = {pr_addr[23:0], b};
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 0) begin
                        pr_verdict = ST_FOUND;
                        pr_phase   = PH_DONE;
                    end
                end
                PH_RDATA: begin
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 0) finish_record();
                end
                default: ;
            endcase
            pr_pos = pr_pos + 1'b1;
        end
        if (is_last) begin
            if (pr_pos < MIN_HEADER_BYTES) begin
                st = ST_SHORT;
            end else if (pr_phase == PH_DONE) begin
                st = pr_verdict;
            end else if (pr_phase == PH_AADDR || pr_phase == PH_RDATA) begin
                if (pr_aleft == 16'd1) st = ST_NO_A;
                else st = ST_MALFORMED;
            end else begin
                st = ST_MALFORMED;
            end
            if (st == ST_UNDECIDED) st = ST_MALFORMED;
            r.status  = st;
            r.address = (st == ST_FOUND) ? pr_addr : 32'h0;
            owed_verdicts.push_back(r);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------ checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (owed_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d address %h",
                         $time, verdict_ch.status, verdict_ch.address);
                fail_count++;
            end else begin
                want = owed_verdicts.pop_front();
                if (verdict_ch.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, verdict_ch.status);
                    fail_count++;
                end
                if (verdict_ch.address !== want.address) begin
                    $display("%0t: address mismatch, expected %h, got %h",
                             $time, want.address, verdict_ch.address);
                    fail_count++;
                end
            end
        end
    end

    // result side: random hold-off per transfer, or a long one on request
    initial begin : result_sink
        int hold;
        verdict_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            hold = rx_eager ? 0 : $urandom_range(0, 10);
            if (rx_hold_cycles != 0) begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold != 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && verdict_ch.valid));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------ byte side
    task automatic send_byte(logic [7:0] b, logic is_last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last      <= is_last;
        do @(posedge i_clk); while (!bytes_ch.ready);
        dns_parse_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        bytes_ch.valid <= 1'b0;
        while (owed_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // sends the first keep bytes of the frame (all of it when keep is 0)
    task automatic send_frame(int keep);
        int n;
        n = (keep <= 0 || keep > frame.size()) ? frame.size() : keep;
        for (int i = 0; i < n; i++) send_byte(frame[i], i == n - 1);
        frame.delete();
    endtask

    // ------------------------------------------------------------ packet building
    function automatic void add_junk(int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    function automatic void add_header(bit response, logic [15:0] qd, logic [15:0] an);
        add_junk(2);
        frame.push_back({response, 7'($urandom)});
        add_junk(1);
        frame.push_back(qd[15:8]);
        frame.push_back(qd[7:0]);
        frame.push_back(an[15:8]);
        frame.push_back(an[7:0]);
        add_junk(4);
    endfunction

    function automatic void add_label(logic [7:0] len);
        frame.push_back(len);
        add_junk(int'(len));
    endfunction

    function automatic void add_name(int labels, bit by_pointer);
        for (int i = 0; i < labels; i++) begin
            if ($urandom_range(0, 19) == 0)
                add_label({2'($urandom_range(1, 2)), 6'($urandom)});
            else
                add_label(8'($urandom_range(1, 6)));
        end
        if (by_pointer) begin
            frame.push_back({2'b11, 6'($urandom)});
            add_junk(1);
        end else begin
            frame.push_back(8'h00);
        end
    endfunction

    function automatic void add_question(int labels, bit by_pointer);
        add_name(labels, by_pointer);
        add_junk(QFIXED_BYTES);
    endfunction

    // record data beyond 48 bytes is left to the caller
    function automatic void add_answer(logic [15:0] rtype, logic [15:0] rdlen,
                                       int labels, bit by_pointer);
        add_name(labels, by_pointer);
        frame.push_back(rtype[15:8]);
        frame.push_back(rtype[7:0]);
        add_junk(6);
        frame.push_back(rdlen[15:8]);
        frame.push_back(rdlen[7:0]);
        add_junk((rdlen > 48) ? 48 : int'(rdlen));
    endfunction

    task automatic send_random_packet();
        int          qd;
        int          an;
        int          keep;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        if ($urandom_range(0, 9) == 0) begin
            add_junk($urandom_range(1, 30));
            send_frame(0);
            return;
        end
        qd = $urandom_range(0, 2);
        an = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
        add_header($urandom_range(0, 15) != 0, 16'(qd), 16'(an));
        if ($urandom_range(0, 29) == 0) begin
            for (int i = 4; i < 8; i++) frame[i] = 8'($urandom);
        end
        repeat (qd) add_question($urandom_range(0, 3), 1'($urandom_range(0, 1)));
        repeat (an) begin
            case ($urandom_range(0, 3))
                0, 1: rtype = 16'h0001;
                2:    rtype = {8'($urandom_range(1, 255)), 8'h01};
                default: rtype = 16'($urandom);
            endcase
            if (rtype == 16'h0001 && $urandom_range(0, 3) != 0) rdlen = 16'd4;
            else rdlen = 16'($urandom_range(0, 8));
            if ($urandom_range(0, 24) == 0) rdlen = 16'($urandom);
            add_answer(rtype, rdlen, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 4));
        if ($urandom_range(0, 7) == 0) frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        keep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame.size()) : 0;
        send_frame(keep);
    endtask

    // ------------------------------------------------------------ tests
    task automatic test_short_packets();
        frame.push_back(8'hFF);
        send_frame(0);
        add_header(1'b1, 16'd1, 16'd1);
        send_frame(MIN_HEADER_BYTES - 1);
    endtask

    task automatic test_header_verdicts();
        add_header(1'b0, 16'd0, 16'd0);
        send_frame(0);
        add_header(1'b1, 16'd0, 16'd0);
        send_frame(0);
        add_header(1'b0, 16'd0, 16'hFFFF);
        send_frame(0);
        // a name is still due when the header ends
        add_header(1'b1, 16'hFFFF, 16'hFFFF);
        send_frame(0);
    endtask

    task automatic test_single_a_record();
        logic [7:0] fill[2] = '{8'h00, 8'hFF};
        foreach (fill[k]) begin
            add_header(1'b1, 16'd0, 16'd1);
            frame.push_back(8'h00);
            frame.push_back(8'h00);
            frame.push_back(8'h01);
            add_junk(6);
            frame.push_back(8'h00);
            frame.push_back(8'h04);
            repeat (ADDR_BYTES) frame.push_back(fill[k]);
            send_frame(0);
        end
    endtask

    task automatic test_compressed_names();
        add_header(1'b1, 16'd2, 16'd2);
        add_question(1, 1'b1);
        add_question(0, 1'b1);
        add_answer(16'h0005, 16'd3, 0, 1'b1);
        add_answer(16'h0001, 16'd4, 0, 1'b1);
        add_junk(8);
        send_frame(0);
        // type with a nonzero top byte is not an A record
        add_header(1'b1, 16'd0, 16'd2);
        add_answer(16'h0101, 16'd4, 1, 1'b0);
        add_answer(16'h0001, 16'd5, 0, 1'b1);
        send_frame(0);
    endtask

    task automatic test_truncation();
        add_header(1'b1, 16'd1, 16'd1);
        add_question(2, 1'b0);
        send_frame(14);
        add_header(1'b1, 16'd1, 16'd1);
        add_question(0, 1'b1);
        send_frame(16);
        add_header(1'b1, 16'd1, 16'd1);
        add_question(0, 1'b1);
        send_frame(18);
        add_header(1'b1, 16'd0, 16'd1);
        add_answer(16'h0001, 16'd4, 0, 1'b0);
        send_frame(18);
        add_header(1'b1, 16'd0, 16'd1);
        add_answer(16'h0001, 16'd4, 0, 1'b0);
        send_frame(25);
        add_header(1'b1, 16'd0, 16'd2);
        add_answer(16'h0001, 16'd4, 0, 1'b0);
        send_frame(25);
        add_header(1'b1, 16'd0, 16'd2);
        add_answer(16'h0005, 16'd6, 0, 1'b0);
        send_frame(26);
        add_header(1'b1, 16'd0, 16'd2);
        add_answer(16'h0010, 16'd0, 0, 1'b1);
        add_answer(16'h0002, 16'd0, 0, 1'b1);
        send_frame(0);
    endtask

    // labels with top bits 01 and 10, then padding past the byte limit
    task automatic test_byte_limit();
        add_header(1'b1, 16'd1, 16'd1);
        add_label(8'h41);
        add_label(8'h80);
        frame.push_back(8'h00);
        add_junk(QFIXED_BYTES);
        add_answer(16'h0001, 16'd4, 0, 1'b0);
        add_junk(520 - frame.size());
        send_frame(0);
    endtask

    task automatic test_back_to_back();
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        repeat (4) send_random_packet();
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    task automatic test_result_backpressure();
        rx_hold_cycles = 150;
        tx_eager       = 1'b1;
        repeat (10) begin
            add_junk($urandom_range(1, 3));
            send_frame(0);
        end
        repeat (3) begin
            add_header(1'b1, 16'd0, 16'd0);
            send_frame(0);
        end
        tx_eager = 1'b0;
        pause_sender();
    endtask

    task automatic test_random_traffic();
        int first_byte;
        int packets;
        first_byte = bytes_sent;
        packets    = 0;
        while (bytes_sent - first_byte < 150 || packets < 4) begin
            send_random_packet();
            packets++;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        bytes_ch.valid     = 1'b0;
        bytes_ch.data_byte = 8'h00;
        bytes_ch.last      = 1'b0;
        clear_parse();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_packets();
        test_header_verdicts();
        test_single_a_record();
        test_compressed_names();
        test_truncation();
        test_byte_limit();
        test_back_to_back();
        test_result_backpressure();
        test_random_traffic();

        pause_sender();
        repeat (16) @(posedge i_clk);
        if (owed_verdicts.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, owed_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/dre_pkg.sv
src/dre_if.sv
src/dre_parser.sv
src/dre_outq.sv
src/dns_response_a_record_extractor.sv
src/dre_checker.sv
sim/dns_response_a_record_extractor_test.sv
